// ----- rtl/lru_key_value_cache_top_defines.svh -----
// Assertion macros shared by the LRU key/value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an implication holds in the following cycle, outside reset.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lkv_pkg.sv -----
// Package for the LRU key/value cache: sizes, codes and the entry type.
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int CAP_W       = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // Register index, taken from the word address bit of paddr.
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

endpackage

// ----- rtl/lru_key_value_cache_top.sv -----
// Top level of the fully associative LRU key/value cache.
//
// Usage:
// - Input channel in_valid/in_stall carries one command item: in_cmd (get or
//   put), in_key and in_value. Every item gives exactly one result item.
// - Result channel out_valid/out_stall carries out_hit, out_read_value and
//   out_evicted. Results appear in the cycle after the item is accepted.
// - Throughput is one item per cycle while no result waits under out_stall: all
//   slots compare the key in parallel and the recency chain moves in the accept
//   cycle, so the next item sees the updated order at once.
// - The slots form a chain ordered by recency, slot 0 most recent. A hit or an
//   insert moves its entry to slot 0 while the slots ahead of it shift down by one.
//   Eviction replaces the entry at the tail of the valid region.
// - While a result waits under out_stall, in_stall is high and nothing moves.
// - Reset (rst_n low, synchronous) empties the cache, drops any pending result
//   and sets capacity to 16. No clearing pass is needed.
// - Capacity (pwdata[4:0]) is written over the APB port at byte address 0; the user
//   must do so only while idle (not enforced); zero counts as one, over 16 as 16.
`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [lkv_pkg::KEY_W-1:0]    in_key,
  input  logic signed [lkv_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [lkv_pkg::VALUE_W-1:0] out_read_value,
  output logic                         out_evicted,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkv_pkg::DATA_W-1:0]   pwdata,
  output logic [lkv_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import lkv_pkg::*;

  // configuration
  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;
  logic [CAP_W-1:0] eff_cap;
  reg_idx_t         reg_sel;
  logic             cfg_wr;

  // chain
  entry_t                  cell_entry [MAX_ENTRIES];
  entry_t                  cell_prev  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  match;
  logic [MAX_ENTRIES-1:0]  shift;
  logic [MAX_ENTRIES-1:0]  vld_vec;
  entry_t                  head;

  // control
  logic                    in_acc;
  logic                    is_put;
  logic                    any_hit;
  logic                    full;
  logic                    upd;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        sel;
  logic signed [VALUE_W-1:0] hit_value;
  logic signed [VALUE_W-1:0] rd_value;
  logic [OCC_W-1:0]        occ_r;
  logic [OCC_W-1:0]        occ_nxt;
  logic [OCC_W-1:0]        occ_dec;

  // output register
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      out_hit_r;
  logic signed [VALUE_W-1:0] out_read_value_r;
  logic                      out_evicted_r;

  // ---------------- configuration port ----------------
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (reg_sel == REG_CAPACITY);
  assign cap_nxt = cfg_wr ? pwdata[CAP_W-1:0] : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_CAPACITY: prdata = DATA_W'(cap_r);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_r > CAP_W'(MAX_ENTRIES)) begin
      eff_cap = CAP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_r;
    end
  end

  // ---------------- handshake ----------------
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // ---------------- lookup ----------------
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_value = hit_value | cell_entry[i].value;
      end
    end
  end

  assign is_put  = (cmd_t'(in_cmd) == CMD_PUT);
  assign any_hit = |match;
  assign full    = (OCC_W'(occ_r) >= OCC_W'(eff_cap));
  assign upd     = in_acc && (any_hit || is_put);
  assign occ_dec = occ_r - OCC_W'(1);

  // Slot that moves to the head: the hit, the tail on eviction, else the first free one.
  always_comb begin
    if (any_hit) begin
      sel = hit_idx;
    end else if (full) begin
      sel = occ_dec[IDX_W-1:0];
    end else begin
      sel = occ_r[IDX_W-1:0];
    end
  end

  assign head = '{valid: 1'b1, key: in_key, value: is_put ? in_value : hit_value};

  always_comb begin
    if (is_put) begin
      rd_value = in_value;
    end else if (any_hit) begin
      rd_value = hit_value;
    end else begin
      rd_value = '1;
    end
  end

  assign occ_nxt = (in_acc && is_put && !any_hit && !full) ? occ_r + OCC_W'(1) : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ---------------- recency chain ----------------
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);

    assign shift[i]   = upd && (CELL_IDX <= sel);
    assign vld_vec[i] = cell_entry[i].valid;

    if (i == 0) begin : g_head
      assign cell_prev[i] = head;
    end else begin : g_link
      assign cell_prev[i] = cell_entry[i-1];
    end

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (shift[i]),
      .prev       (cell_prev[i]),
      .lookup_key (in_key),
      .entry      (cell_entry[i]),
      .match      (match[i])
    );
  end

  // ---------------- result register ----------------
  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_hit_r        <= any_hit;
      out_read_value_r <= rd_value;
      out_evicted_r    <= is_put && !any_hit && full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_evicted    = out_evicted_r;

  // ---------------- assertions ----------------
  `LKV_ASSERT(a_key_unique, $onehot0(match), "key matches more than one slot")
  `LKV_ASSERT(a_occ_range, occ_r <= OCC_W'(MAX_ENTRIES), "occupancy beyond slot count")
  `LKV_ASSERT(a_valid_packed, $countones(vld_vec) == int'(occ_r) &&
              (vld_vec & (vld_vec + MAX_ENTRIES'(1))) == '0,
              "valid slots not packed at chain head")
  `LKV_ASSERT(a_evict_miss, !(out_valid_r && out_evicted_r && out_hit_r),
              "eviction reported on a hit")
  `LKV_ASSERT_NEXT(a_insert_grows, in_acc && is_put && !any_hit && !full,
                   occ_r == $past(occ_r) + OCC_W'(1), "insert did not grow occupancy")

endmodule

// ----- rtl/lkv_cell.sv -----
// One recency slot of the LRU chain: holds an entry, compares its key, shifts.
module lkv_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  lkv_pkg::entry_t     prev,
  input  logic [lkv_pkg::KEY_W-1:0] lookup_key,
  output lkv_pkg::entry_t     entry,
  output logic                match
);
  import lkv_pkg::*;

  logic                      vld_r;
  logic                      vld_nxt;
  logic [KEY_W-1:0]          key_r;
  logic signed [VALUE_W-1:0] value_r;

  assign vld_nxt = shift ? prev.valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Take the neighbor's entry when the chain advances through this slot.
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev.key;
      value_r <= prev.value;
    end
  end

  assign entry = '{valid: vld_r, key: key_r, value: value_r};
  assign match = vld_r && (key_r == lookup_key);

endmodule
